/* hw/rtl/esbdw_pkg.sv */
// ----------------------------------------------------------------------------
// esbdw_pkg
// Shared types and constants for the elastic sample buffer with drift warp.
// ----------------------------------------------------------------------------
package esbdw_pkg;

  localparam int FIFO_DEPTH_DEF = 256;
  localparam int MAX_BLOCK_DEF  = 64;

  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 7;
  localparam int LEVEL_W   = 9;
  localparam int SLIP_W    = 2;
  localparam int CFG_IDX_W = 1;

  // warp is only done on blocks of at least this many samples
  localparam int MIN_WARP_LEN = 3;

  // reciprocal of the block length is floor(2^RECIP_SHIFT / n)
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 22;

  localparam logic [LEVEL_W-1:0] TARGET_FILL_RST = 9'd64;
  localparam logic [LEVEL_W-1:0] HIGH_WATER_RST  = 9'd128;

  localparam logic signed [SLIP_W-1:0] SLIP_NONE     = 2'sb00;
  localparam logic signed [SLIP_W-1:0] SLIP_STRETCH  = 2'sb01;
  localparam logic signed [SLIP_W-1:0] SLIP_COMPRESS = 2'sb11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_FILL = 1'b0,
    REG_HIGH_WATER  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // divider kick-off for a new block
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] n;
  } warp_ctl_t;

  // one interpolation request: a + (b - a) * r / n
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic [LEN_W-1:0]           r;
    logic                       last;
  } warp_req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } warp_res_t;

endpackage

/* hw/rtl/elastic_sample_buffer_drift_warp.sv */
// ----------------------------------------------------------------------------
// elastic_sample_buffer_drift_warp
// Ring FIFO of mic samples with block fetch and drift compensation by
// linear time warp (stretch or compress one sample per block).
//
// A push (start with in_operation = 0) leaves busy low.
// A fetch of n samples raises busy; it first copies the samples it takes out
// of the FIFO RAM into the block RAM, one per cycle. A plain block then
// streams out at one sample per cycle once the copy ends. A warped block
// waits for the per-block reciprocal divider (started at the fetch, running
// alongside the copy) and then reads two block RAM entries for each
// interpolated sample and feeds them to the interpolation pipeline. Results
// come out on out_valid strobes that cannot be held off; busy drops as the
// last sample of the block is presented. No memory is cleared after reset;
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module elastic_sample_buffer_drift_warp #(
  parameter int FIFO_DEPTH = esbdw_pkg::FIFO_DEPTH_DEF,
  parameter int MAX_BLOCK  = esbdw_pkg::MAX_BLOCK_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_operation,
  input  logic signed [esbdw_pkg::SAMPLE_W-1:0]   in_mic_sample,
  input  logic [esbdw_pkg::LEN_W-1:0]             in_block_length,

  output logic                                    out_valid,
  output logic signed [esbdw_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                    out_last,
  output logic signed [esbdw_pkg::SLIP_W-1:0]     out_slip,
  output logic                                    out_short_read,

  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [esbdw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [esbdw_pkg::LEVEL_W-1:0]           cfg_data
);

  localparam int SAMPLE_W = esbdw_pkg::SAMPLE_W;
  localparam int LEN_W    = esbdw_pkg::LEN_W;
  localparam int LEVEL_W  = esbdw_pkg::LEVEL_W;
  localparam int SLIP_W   = esbdw_pkg::SLIP_W;
  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
  localparam int BLK_AW   = $clog2(MAX_BLOCK);
  localparam int FILL_W   = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W    = ((FILL_W > LEVEL_W) ? FILL_W : LEVEL_W) + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT,
    S_WARP
  } state_t;

  state_t                     state_r;
  logic                       busy_r;
  logic [FILL_W-1:0]          fill_r;
  logic [FIFO_AW-1:0]         wr_idx_r, rd_idx_r;
  logic [FIFO_AW-1:0]         wr_idx_nxt, rd_idx_nxt;
  logic [LEVEL_W-1:0]         target_r, hw_r;
  logic signed [SAMPLE_W-1:0] held_r;

  logic [LEN_W-1:0]           n_r, got_r, rc_r, k_r;
  logic signed [SLIP_W-1:0]   slip_r;
  logic                       compress_r, short_r;

  logic                       rd_pend_r;
  logic [BLK_AW-1:0]          pend_addr_r;
  logic                       pend_valid_r, pend_ram_r, pend_last_r;

  logic                       half_r;
  logic signed [SAMPLE_W-1:0] a_cap_r;
  logic                       wreq_valid_r, wreq_last_r;
  logic [LEN_W-1:0]           wreq_r_r;

  logic                       out_valid_r, out_last_r, out_short_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SLIP_W-1:0]   out_slip_r;

  // fetch decision
  logic [LEN_W-1:0] n_in, want, got_in;
  logic [CMP_W-1:0] avail_x;
  logic [LEN_W:0]   need;
  logic             stretch, compress, warp_in, short_in;
  logic             push_go, fetch_go;

  always_comb begin
    n_in     = (in_block_length > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : in_block_length;
    avail_x  = CMP_W'(fill_r);
    stretch  = avail_x < CMP_W'(target_r);
    compress = !stretch && (avail_x > CMP_W'(hw_r) + CMP_W'(n_in));
    want     = (stretch && n_in != LEN_W'(MAX_BLOCK)) ? n_in + 1'b1 : n_in;
    got_in   = (avail_x < CMP_W'(want)) ? LEN_W'(fill_r) : want;
    need     = {1'b0, n_in} + (LEN_W + 1)'(stretch);
    warp_in  = (stretch || compress) && ({1'b0, got_in} >= need)
               && (n_in >= LEN_W'(esbdw_pkg::MIN_WARP_LEN));
    short_in = got_in < n_in;

    push_go  = start && !busy_r
               && (esbdw_pkg::op_t'(in_operation) == esbdw_pkg::OP_PUSH)
               && (fill_r < FILL_W'(FIFO_DEPTH));
    fetch_go = start && !busy_r
               && (esbdw_pkg::op_t'(in_operation) == esbdw_pkg::OP_FETCH)
               && (n_in != '0);

    wr_idx_nxt = (wr_idx_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
    rd_idx_nxt = (rd_idx_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
  end

  // FIFO RAM
  logic                fifo_we, fifo_re;
  logic [SAMPLE_W-1:0] fifo_rdata;

  assign fifo_we = push_go;
  assign fifo_re = (state_r == S_READ) && (rc_r < got_r);

  esbdw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (wr_idx_r),
    .wr_data (in_mic_sample),
    .rd_en   (fifo_re),
    .rd_addr (rd_idx_r),
    .rd_data (fifo_rdata)
  );

  // source index and phase of warped sample k
  logic [LEN_W-1:0] i0, rr;

  always_comb begin
    if (!compress_r) begin
      i0 = k_r;
      rr = k_r;
    end else if (k_r == '0) begin
      i0 = '0;
      rr = '0;
    end else if (k_r == n_r - 1'b1) begin
      // past the end of the shortened source: extrapolate from the last pair
      i0 = n_r - LEN_W'(3);
      rr = n_r + 1'b1;
    end else begin
      i0 = k_r - 1'b1;
      rr = n_r - k_r;
    end
  end

  // block RAM
  logic                 recip_ready;
  logic                 warp_issue;
  logic                 blk_re;
  logic [BLK_AW-1:0]    blk_raddr;
  logic [SAMPLE_W-1:0]  blk_rdata;
  logic [LEN_W-1:0]     i1;

  always_comb begin
    warp_issue = (state_r == S_WARP) && (k_r < n_r) && recip_ready;
    i1         = i0 + 1'b1;
    blk_re     = 1'b0;
    blk_raddr  = k_r[BLK_AW-1:0];
    if (state_r == S_OUT) begin
      blk_re = (k_r < n_r) && (k_r < got_r);
    end else if (warp_issue) begin
      blk_re    = 1'b1;
      blk_raddr = half_r ? i1[BLK_AW-1:0] : i0[BLK_AW-1:0];
    end
  end

  esbdw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_BLOCK)
  ) u_blk_ram (
    .clk     (clk),
    .wr_en   (rd_pend_r),
    .wr_addr (pend_addr_r),
    .wr_data (fifo_rdata),
    .rd_en   (blk_re),
    .rd_addr (blk_raddr),
    .rd_data (blk_rdata)
  );

  // interpolation unit
  esbdw_pkg::warp_ctl_t wctl;
  esbdw_pkg::warp_req_t wreq;
  esbdw_pkg::warp_res_t wres;

  always_comb begin
    wctl.start  = fetch_go && warp_in;
    wctl.n      = n_in;
    wreq.valid  = wreq_valid_r;
    wreq.a      = a_cap_r;
    wreq.b      = $signed(blk_rdata);
    wreq.r      = wreq_r_r;
    wreq.last   = wreq_last_r;
  end

  esbdw_warp u_warp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (wctl),
    .recip_ready (recip_ready),
    .req         (wreq),
    .res         (wres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= 1'b0;
      fill_r       <= '0;
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      held_r       <= '0;
      target_r     <= esbdw_pkg::TARGET_FILL_RST;
      hw_r         <= esbdw_pkg::HIGH_WATER_RST;
      rc_r         <= '0;
      k_r          <= '0;
      half_r       <= 1'b0;
      rd_pend_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      wreq_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pend_r    <= fifo_re;
      pend_valid_r <= (state_r == S_OUT) && (k_r < n_r);
      wreq_valid_r <= warp_issue && half_r;

      if (cfg_valid) begin
        unique case (esbdw_pkg::cfg_reg_t'(cfg_index))
          esbdw_pkg::REG_TARGET_FILL: target_r <= cfg_data;
          esbdw_pkg::REG_HIGH_WATER:  hw_r     <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (push_go) begin
            wr_idx_r <= wr_idx_nxt;
            fill_r   <= fill_r + 1'b1;
          end
          if (fetch_go) begin
            n_r        <= n_in;
            got_r      <= got_in;
            slip_r     <= warp_in ? (stretch ? esbdw_pkg::SLIP_STRETCH
                                             : esbdw_pkg::SLIP_COMPRESS)
                                  : esbdw_pkg::SLIP_NONE;
            compress_r <= compress;
            short_r    <= short_in;
            fill_r     <= fill_r - FILL_W'(got_in);
            rc_r       <= '0;
            k_r        <= '0;
            half_r     <= 1'b0;
            busy_r     <= 1'b1;
            state_r    <= (got_in != '0) ? S_READ : S_OUT;
          end
        end

        S_READ: begin
          if (fifo_re) begin
            rd_idx_r    <= rd_idx_nxt;
            rc_r        <= rc_r + 1'b1;
            pend_addr_r <= rc_r[BLK_AW-1:0];
          end
          // held sample tracks the newest sample taken from the FIFO
          if (rd_pend_r) begin
            held_r <= $signed(fifo_rdata);
          end
          if ((rc_r == got_r) && !rd_pend_r) begin
            state_r <= (slip_r != esbdw_pkg::SLIP_NONE) ? S_WARP : S_OUT;
          end
        end

        S_OUT: begin
          if (k_r < n_r) begin
            pend_ram_r   <= k_r < got_r;
            pend_last_r  <= k_r == n_r - 1'b1;
            k_r          <= k_r + 1'b1;
          end
        end

        S_WARP: begin
          if (warp_issue) begin
            if (!half_r) begin
              half_r <= 1'b1;
            end else begin
              half_r       <= 1'b0;
              a_cap_r      <= $signed(blk_rdata);
              k_r          <= k_r + 1'b1;
              wreq_r_r     <= rr;
              wreq_last_r  <= k_r == n_r - 1'b1;
            end
          end
        end

        default: ;
      endcase

      // result register
      out_valid_r <= pend_valid_r || wres.valid;
      if (pend_valid_r) begin
        out_sample_r <= pend_ram_r ? $signed(blk_rdata) : held_r;
        out_last_r   <= pend_last_r;
        out_slip_r   <= slip_r;
        out_short_r  <= short_r;
      end else if (wres.valid) begin
        out_sample_r <= wres.sample;
        out_last_r   <= wres.last;
        out_slip_r   <= slip_r;
        out_short_r  <= short_r;
      end
      if ((pend_valid_r && pend_last_r) || (wres.valid && wres.last)) begin
        state_r <= S_IDLE;
        busy_r  <= 1'b0;
      end
    end
  end

  assign busy           = busy_r;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_last       = out_last_r;
  assign out_slip       = out_slip_r;
  assign out_short_read = out_short_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FIFO_DEPTH))
    else $error("fill level above FIFO depth");

  a_fifo_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_we && fifo_re))
    else $error("FIFO RAM written and read in the same cycle");

  a_blk_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_pend_r && blk_re))
    else $error("block RAM written and read in the same cycle");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> busy_r)
    else $error("block sample emitted while idle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result directly after the end of a block");
`endif

endmodule

/* hw/rtl/esbdw_ram.sv */
// ----------------------------------------------------------------------------
// esbdw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module esbdw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/esbdw_warp.sv */
// ----------------------------------------------------------------------------
// esbdw_warp
// Interpolation datapath: a + trunc((b - a) * r / n), saturated to 16 bits.
// Division by n uses a reciprocal built once per block by a serial divider,
// then a multiply, one correction step and the final add, in four stages.
// ----------------------------------------------------------------------------
module esbdw_warp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  esbdw_pkg::warp_ctl_t  ctl,
  output logic                  recip_ready,
  input  esbdw_pkg::warp_req_t  req,
  output esbdw_pkg::warp_res_t  res
);

  localparam int SAMPLE_W  = esbdw_pkg::SAMPLE_W;
  localparam int LEN_W     = esbdw_pkg::LEN_W;
  localparam int RECIP_W   = esbdw_pkg::RECIP_W;
  localparam int DIV_STEPS = esbdw_pkg::RECIP_SHIFT + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int PROD_W    = DIFF_W + LEN_W + 1;
  localparam int X_W       = esbdw_pkg::RECIP_SHIFT;
  localparam int XM_W      = X_W + RECIP_W;
  localparam int Q_W       = RECIP_W;
  localparam int QN_W      = Q_W + LEN_W;
  localparam int REM_W     = LEN_W + 1;
  localparam int SUM_W     = Q_W + 2;
  localparam int SAT_HI    = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_LO    = -(2 ** (SAMPLE_W - 1));

  // reciprocal divider
  logic [LEN_W-1:0]   n_r;
  logic [STEP_W-1:0]  step_r;
  logic               div_run_r;
  logic [LEN_W-1:0]   rem_r;
  logic [RECIP_W-1:0] recip_r;
  logic [LEN_W:0]     trial;
  logic [LEN_W:0]     trial_sub;
  logic               fits;

  always_comb begin
    // dividend is a single one followed by zeros, fed MSB first
    trial     = {rem_r, (step_r == '0)};
    fits      = trial >= {1'b0, n_r};
    trial_sub = fits ? trial - {1'b0, n_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
      step_r    <= '0;
    end else if (ctl.start) begin
      n_r       <= ctl.n;
      step_r    <= '0;
      rem_r     <= '0;
      div_run_r <= 1'b1;
    end else if (div_run_r) begin
      rem_r   <= trial_sub[LEN_W-1:0];
      recip_r <= {recip_r[RECIP_W-2:0], fits};
      step_r  <= step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        div_run_r <= 1'b0;
      end
    end
  end

  assign recip_ready = !div_run_r;

  // stage 1: difference times phase
  logic signed [PROD_W-1:0]   diff_x;
  logic signed [PROD_W-1:0]   r_x;
  logic                       v1_r, l1_r;
  logic signed [SAMPLE_W-1:0] a1_r;
  logic signed [PROD_W-1:0]   p1_r;

  always_comb begin
    diff_x = PROD_W'(req.b) - PROD_W'(req.a);
    r_x    = $signed({{(PROD_W-LEN_W){1'b0}}, req.r});
  end

  // stage 2: magnitude times reciprocal
  logic [PROD_W-1:0]          mag;
  logic [X_W-1:0]             x_in;
  logic                       v2_r, l2_r, neg2_r;
  logic signed [SAMPLE_W-1:0] a2_r;
  logic [X_W-1:0]             x2_r;
  logic [XM_W-1:0]            xm2_r;

  always_comb begin
    mag  = p1_r[PROD_W-1] ? PROD_W'(-p1_r) : PROD_W'(p1_r);
    x_in = mag[X_W-1:0];
  end

  // stage 3: estimate quotient, remainder for the correction
  logic [Q_W-1:0]             q0;
  logic [QN_W-1:0]            qn;
  logic [X_W-1:0]             rem_full;
  logic                       v3_r, l3_r, neg3_r;
  logic signed [SAMPLE_W-1:0] a3_r;
  logic [Q_W-1:0]             q3_r;
  logic [REM_W-1:0]           rem3_r;

  always_comb begin
    q0       = xm2_r[XM_W-1:esbdw_pkg::RECIP_SHIFT];
    qn       = q0 * n_r;
    rem_full = x2_r - qn[X_W-1:0];
  end

  // stage 4: correct, apply sign, add, saturate
  logic [Q_W-1:0]             q4;
  logic signed [SUM_W-1:0]    sq;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       v4_r, l4_r;
  logic signed [SAMPLE_W-1:0] s4_r;

  always_comb begin
    q4  = q3_r + Q_W'(rem3_r >= {1'b0, n_r});
    sq  = neg3_r ? -$signed({2'b00, q4}) : $signed({2'b00, q4});
    sum = SUM_W'(a3_r) + sq;
    if (sum > SUM_W'(SAT_HI)) begin
      sat = SAMPLE_W'(SAT_HI);
    end else if (sum < SUM_W'(SAT_LO)) begin
      sat = SAMPLE_W'(SAT_LO);
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r   <= diff_x * r_x;
    a1_r   <= req.a;
    l1_r   <= req.last;

    xm2_r  <= x_in * recip_r;
    x2_r   <= x_in;
    neg2_r <= p1_r[PROD_W-1];
    a2_r   <= a1_r;
    l2_r   <= l1_r;

    q3_r   <= q0;
    rem3_r <= rem_full[REM_W-1:0];
    neg3_r <= neg2_r;
    a3_r   <= a2_r;
    l3_r   <= l2_r;

    s4_r   <= sat;
    l4_r   <= l3_r;
  end

  always_comb begin
    res.valid  = v4_r;
    res.sample = s4_r;
    res.last   = l4_r;
  end

`ifndef SYNTH
  a_req_after_recip: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> recip_ready)
    else $error("interpolation request while reciprocal is still running");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !recip_ready)
    else $error("reciprocal divider did not start");
`endif

endmodule
